// File: src/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants of the token scanner
// Token kinds, character codes, the reserved word table and the character
// classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

  localparam int KW_COUNT = 10;
  localparam int KW_MAX   = 5;

  // Token kinds.
  localparam logic [4:0] K_COMMENT = 5'd10;
  localparam logic [4:0] K_ID      = 5'd11;
  localparam logic [4:0] K_REAL    = 5'd12;
  localparam logic [4:0] K_STRING  = 5'd13;
  localparam logic [4:0] K_PLUS    = 5'd14;
  localparam logic [4:0] K_MUL     = 5'd15;
  localparam logic [4:0] K_ASSIGN  = 5'd16;
  localparam logic [4:0] K_EQ      = 5'd17;
  localparam logic [4:0] K_GT      = 5'd18;
  localparam logic [4:0] K_LT      = 5'd19;
  localparam logic [4:0] K_LPAREN  = 5'd20;
  localparam logic [4:0] K_COMMA   = 5'd21;
  localparam logic [4:0] K_RPAREN  = 5'd22;
  localparam logic [4:0] K_SEMI    = 5'd23;
  localparam logic [4:0] K_INVALID = 5'd24;
  localparam logic [4:0] K_DIV     = 5'd25;
  localparam logic [4:0] K_INT     = 5'd26;
  localparam logic [4:0] K_END     = 5'd27;

  // Character codes.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // Reserved words, padded with zero: AND BEGIN END FOR IF NOT OR READ WHILE WRITE.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
    '{8'h41, 8'h4E, 8'h44, 8'h00, 8'h00},
    '{8'h42, 8'h45, 8'h47, 8'h49, 8'h4E},
    '{8'h45, 8'h4E, 8'h44, 8'h00, 8'h00},
    '{8'h46, 8'h4F, 8'h52, 8'h00, 8'h00},
    '{8'h49, 8'h46, 8'h00, 8'h00, 8'h00},
    '{8'h4E, 8'h4F, 8'h54, 8'h00, 8'h00},
    '{8'h4F, 8'h52, 8'h00, 8'h00, 8'h00},
    '{8'h52, 8'h45, 8'h41, 8'h44, 8'h00},
    '{8'h57, 8'h48, 8'h49, 8'h4C, 8'h45},
    '{8'h57, 8'h52, 8'h49, 8'h54, 8'h45}
  };

  localparam logic [7:0] KW_LEN [KW_COUNT] = '{
    8'd3, 8'd5, 8'd3, 8'd3, 8'd2, 8'd3, 8'd2, 8'd4, 8'd5, 8'd5
  };

  // One result waiting in the output queue.
  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] lexeme_length;
    logic       last;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Kind of a character that forms a token by itself.
  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      CH_PLUS:   k = K_PLUS;
      CH_STAR:   k = K_MUL;
      CH_EQ:     k = K_EQ;
      CH_GT:     k = K_GT;
      CH_LT:     k = K_LT;
      CH_LPAREN: k = K_LPAREN;
      CH_COMMA:  k = K_COMMA;
      CH_RPAREN: k = K_RPAREN;
      default:   k = K_INVALID;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: src/tsc_in_if.sv
// ----------------------------------------------------------------------------
// tsc_in_if: character channel of the token scanner
// Valid/ready channel carrying one source character or an end-of-text mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: src/tsc_out_if.sv
// ----------------------------------------------------------------------------
// tsc_out_if: token channel of the token scanner
// Valid/ready channel carrying one token kind with its lexeme length.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic [7:0] lexeme_length;
  logic       last;

  modport source (output valid, output token_kind, output lexeme_length, output last,
                  input ready);
  modport sink   (input valid, input token_kind, input lexeme_length, input last,
                  output ready);
endinterface

`default_nettype wire

// File: src/token_scanner.sv
// ----------------------------------------------------------------------------
// token_scanner: streaming lexical analyzer
// Turns a stream of ASCII characters into token kinds and lexeme lengths.
// ----------------------------------------------------------------------------
// Usage:
// in_ch takes one character per transfer; end_of_text marks the end of the
// text and flushes the pending token followed by an end token. out_ch gives
// one token per transfer, with last set on the final token caused by one
// input transfer (a character may close the previous token and form one of
// its own, so one input gives zero, one or two tokens).
// An input transfer is registered, then decoded in the next cycle by the
// scanner state machine and the parallel reserved word compare, and its
// tokens are written into an eight-entry output queue, whose head drives
// out_ch directly. Throughput is one character per cycle while the queue
// has room; the output side moves one token per cycle, so a run of
// two-token characters is limited by out_ch. in_ch.ready drops when the
// queue could not take the tokens of the registered item and of a new one.
// When out_ch stalls, the queue fills and then in_ch stalls.
// Reset (synchronous, rst_n low) empties the queue and puts the scanner
// between tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module token_scanner
  import tsc_pkg::*;
#(
  parameter int KEYWORD_CHARS = 5
) (
  input  wire       clk,
  input  wire       rst_n,
  tsc_in_if.sink    in_ch,
  tsc_out_if.source out_ch
);

  localparam int PFX_AW     = $clog2(KEYWORD_CHARS);
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_WORD      = 4'd1;
  localparam logic [3:0] M_INT       = 4'd2;
  localparam logic [3:0] M_DOT       = 4'd3;
  localparam logic [3:0] M_REAL      = 4'd4;
  localparam logic [3:0] M_SLASH     = 4'd5;
  localparam logic [3:0] M_COMM      = 4'd6;
  localparam logic [3:0] M_COMM_STAR = 4'd7;
  localparam logic [3:0] M_STR       = 4'd8;
  localparam logic [3:0] M_COLON     = 4'd9;
  localparam logic [3:0] M_SEMI      = 4'd10;

  // Input register.
  logic       v1_r;
  logic [7:0] ch_r;
  logic       eot_r;

  // Scanner state.
  logic [3:0] mode_r, mode_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       kwp_r, kwp_nxt;
  logic [7:0] pfx_r [KEYWORD_CHARS];

  // Output queue.
  res_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [3:0]         fcnt_r;

  logic              in_ready;
  logic              in_xfer;
  logic              out_xfer;
  logic [4:0]        word_kind;
  logic [7:0]        cnt_inc;
  logic              start;
  logic              pre_v, post_v;
  logic [4:0]        pre_k, post_k;
  logic [7:0]        pre_l, post_l;
  logic              pfx_we;
  logic [PFX_AW-1:0] pfx_idx;
  logic [1:0]        push_n;
  res_t              res0, res1;
  logic [7:0]        c;

  assign in_ready    = ({1'b0, fcnt_r} + (v1_r ? 5'd2 : 5'd0)) <= 5'(FIFO_DEPTH - 2);
  assign in_ch.ready = in_ready;
  assign in_xfer     = in_ch.valid && in_ready;

  assign out_ch.valid         = fcnt_r != 4'd0;
  assign out_ch.token_kind    = fifo_r[rp_r].token_kind;
  assign out_ch.lexeme_length = fifo_r[rp_r].lexeme_length;
  assign out_ch.last          = fifo_r[rp_r].last;
  assign out_xfer             = out_ch.valid && out_ch.ready;

  // Reserved word compare against the stored prefix; the length match
  // guarantees that only entries written for this word are looked at.
  always_comb begin
    logic hit;
    word_kind = K_ID;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      hit = (KW_LEN[k] == cnt_r);
      for (int i = 0; i < KW_MAX; i++) begin
        if (8'(i) < KW_LEN[k] && pfx_r[i] != KW_TEXT[k][i]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        word_kind = 5'(k);
      end
    end
    if (!kwp_r) begin
      word_kind = K_ID;
    end
  end

  always_comb begin
    c        = ch_r;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    kwp_nxt  = kwp_r;
    pfx_we   = 1'b0;
    pfx_idx  = '0;
    start    = 1'b0;
    pre_v    = 1'b0;
    pre_k    = K_INVALID;
    pre_l    = cnt_r;
    post_v   = 1'b0;
    post_k   = K_INVALID;
    post_l   = 8'd1;
    cnt_inc  = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;

    if (eot_r) begin
      pre_v = 1'b1;
      unique case (mode_r) inside
        M_WORD:  pre_k = word_kind;
        M_INT:   pre_k = K_INT;
        M_REAL:  pre_k = K_REAL;
        M_SLASH: pre_k = K_DIV;
        M_SEMI:  pre_k = K_SEMI;
        M_DOT, M_COMM, M_COMM_STAR, M_STR, M_COLON: pre_k = K_INVALID;
        default: pre_v = 1'b0;
      endcase
      post_v   = 1'b1;
      post_k   = K_END;
      post_l   = 8'd0;
      mode_nxt = M_IDLE;
      cnt_nxt  = 8'd0;
    end else begin
      unique case (mode_r) inside
        M_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (kwp_r) begin
              if (cnt_r < 8'(KEYWORD_CHARS)) begin
                pfx_we  = 1'b1;
                pfx_idx = cnt_r[PFX_AW-1:0];
              end else begin
                kwp_nxt = 1'b0;
              end
            end
            cnt_nxt = cnt_inc;
          end else begin
            pre_v = 1'b1;
            pre_k = word_kind;
            start = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            cnt_nxt = cnt_inc;
          end else if (c == CH_DOT) begin
            cnt_nxt  = cnt_inc;
            mode_nxt = M_DOT;
          end else begin
            pre_v = 1'b1;
            pre_k = K_INT;
            start = 1'b1;
          end
        end
        M_DOT, M_REAL: begin
          if (is_digit(c)) begin
            cnt_nxt  = cnt_inc;
            mode_nxt = M_REAL;
          end else begin
            pre_v = 1'b1;
            pre_k = (mode_r == M_DOT) ? K_INVALID : K_REAL;
            start = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_STAR) begin
            cnt_nxt  = cnt_inc;
            mode_nxt = M_COMM;
          end else begin
            pre_v = 1'b1;
            pre_k = K_DIV;
            start = 1'b1;
          end
        end
        M_COMM: begin
          cnt_nxt = cnt_inc;
          if (c == CH_STAR) begin
            mode_nxt = M_COMM_STAR;
          end
        end
        M_COMM_STAR: begin
          cnt_nxt = cnt_inc;
          if (c == CH_SLASH) begin
            pre_v    = 1'b1;
            pre_k    = K_COMMENT;
            pre_l    = cnt_inc;
            mode_nxt = M_IDLE;
            cnt_nxt  = 8'd0;
          end else if (c != CH_STAR) begin
            mode_nxt = M_COMM;
          end
        end
        M_STR: begin
          cnt_nxt = cnt_inc;
          if (c == CH_QUOTE) begin
            pre_v    = 1'b1;
            pre_k    = K_STRING;
            pre_l    = cnt_inc;
            mode_nxt = M_IDLE;
            cnt_nxt  = 8'd0;
          end
        end
        M_COLON, M_SEMI: begin
          pre_v = 1'b1;
          if (c == CH_EQ) begin
            pre_k    = K_ASSIGN;
            pre_l    = 8'd2;
            mode_nxt = M_IDLE;
            cnt_nxt  = 8'd0;
          end else begin
            pre_k = (mode_r == M_COLON) ? K_INVALID : K_SEMI;
            pre_l = 8'd1;
            start = 1'b1;
          end
        end
        default: start = 1'b1;
      endcase
    end

    // Between tokens a space is skipped; others open a token or stand alone.
    if (start) begin
      mode_nxt = M_IDLE;
      cnt_nxt  = 8'd1;
      if (is_space(c)) begin
        cnt_nxt = 8'd0;
      end else if (is_alpha(c)) begin
        mode_nxt = M_WORD;
        kwp_nxt  = 1'b1;
        pfx_we   = 1'b1;
        pfx_idx  = '0;
      end else if (is_digit(c)) begin
        mode_nxt = M_INT;
      end else if (c == CH_SLASH) begin
        mode_nxt = M_SLASH;
      end else if (c == CH_COLON) begin
        mode_nxt = M_COLON;
      end else if (c == CH_SEMI) begin
        mode_nxt = M_SEMI;
      end else if (c == CH_QUOTE) begin
        mode_nxt = M_STR;
      end else begin
        post_v  = 1'b1;
        post_k  = op_kind(c);
        post_l  = 8'd1;
        cnt_nxt = 8'd0;
      end
    end
  end

  // Pack the tokens of this item into queue order.
  always_comb begin
    res1 = '{token_kind: post_k, lexeme_length: post_l, last: 1'b1};
    if (pre_v) begin
      res0 = '{token_kind: pre_k, lexeme_length: pre_l, last: !post_v};
    end else begin
      res0 = res1;
    end
    push_n = v1_r ? (2'(pre_v) + 2'(post_v)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      mode_r <= M_IDLE;
      cnt_r  <= 8'd0;
      kwp_r  <= 1'b1;
      wp_r   <= '0;
      rp_r   <= '0;
      fcnt_r <= 4'd0;
    end else begin
      v1_r <= in_xfer;
      if (v1_r) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
        kwp_r  <= kwp_nxt;
      end
      wp_r   <= wp_r + FIFO_AW'(push_n);
      if (out_xfer) begin
        rp_r <= rp_r + FIFO_AW'(1);
      end
      fcnt_r <= fcnt_r + 4'(push_n) - 4'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch_r  <= in_ch.char_code;
      eot_r <= in_ch.end_of_text;
    end
    if (v1_r && pfx_we && !eot_r) begin
      pfx_r[pfx_idx] <= c;
    end
    if (push_n != 2'd0) begin
      fifo_r[wp_r] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wp_r + FIFO_AW'(1)] <= res1;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= 4'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && eot_r |=> mode_r == M_IDLE && cnt_r == 8'd0)
    else $error("scanner not idle after end of text");

  a_eot_push: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && eot_r |-> push_n != 2'd0 && res1.token_kind == K_END)
    else $error("end of text did not produce an end token");

  a_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> v1_r)
    else $error("accepted character lost before decode");

endmodule

`default_nettype wire
